// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the 64-bit Jacobi symbol core.
package jsu_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned SYM_W  = 2;

   localparam logic [2:0] MOD8_THREE = 3'd3;
   localparam logic [2:0] MOD8_FIVE  = 3'd5;
   localparam logic [1:0] MOD4_THREE = 2'd3;

   localparam logic [SYM_W-1:0] SYM_ZERO = 2'b00;
   localparam logic [SYM_W-1:0] SYM_POS  = 2'b01;
   localparam logic [SYM_W-1:0] SYM_NEG  = 2'b11;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic a_zero;
   } status_type;

endpackage

// ===== rtl/jsu_datapath.sv =====
// Operand registers, binary reduction step and symbol formation.
module jsu_datapath (
   input  logic                            clock,
   input  jsu_pkg::cmd_type                cmd,
   input  logic [jsu_pkg::WORD_W-1:0]      a_value,
   input  logic [jsu_pkg::WORD_W-1:0]      n_modulus,
   output jsu_pkg::status_type             status,
   output logic signed [jsu_pkg::SYM_W-1:0] symbol
);

   logic [jsu_pkg::WORD_W-1:0] a_ff, a_in;
   logic [jsu_pkg::WORD_W-1:0] n_ff, n_in;
   logic                       neg_ff, neg_in;

   logic                       a_ge_n;
   logic [jsu_pkg::WORD_W-1:0] diff;
   logic [jsu_pkg::WORD_W-1:0] n_next;
   logic                       swap_flip;
   logic                       two_flip;

   assign a_ge_n    = (a_ff >= n_ff);
   assign diff      = a_ge_n ? (a_ff - n_ff) : (n_ff - a_ff);
   assign swap_flip = !a_ge_n && (a_ff[1:0] == jsu_pkg::MOD4_THREE)
                      && (n_ff[1:0] == jsu_pkg::MOD4_THREE);

   always_comb begin
      a_in   = a_ff;
      n_in   = n_ff;
      neg_in = neg_ff;
      n_next = n_ff;
      two_flip = 1'b0;
      if (cmd.load) begin
         if (n_modulus[0]) begin
            a_in = a_value;
            n_in = n_modulus;
         end else begin
            a_in = '0;
            n_in = '0;
         end
         neg_in = 1'b0;
      end else if (cmd.step) begin
         if (!a_ff[0]) begin
            a_in = {1'b0, a_ff[jsu_pkg::WORD_W-1:1]};
            two_flip = (n_ff[2:0] == jsu_pkg::MOD8_THREE)
                       || (n_ff[2:0] == jsu_pkg::MOD8_FIVE);
            neg_in = neg_ff ^ two_flip;
         end else begin
            n_next = a_ge_n ? n_ff : a_ff;
            a_in   = {1'b0, diff[jsu_pkg::WORD_W-1:1]};
            n_in   = n_next;
            two_flip = (n_next[2:0] == jsu_pkg::MOD8_THREE)
                       || (n_next[2:0] == jsu_pkg::MOD8_FIVE);
            neg_in = neg_ff ^ swap_flip ^ two_flip;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      n_ff   <= n_in;
      neg_ff <= neg_in;
   end

   assign status.a_zero = (a_ff == '0);

   always_comb begin
      if (n_ff == jsu_pkg::WORD_W'(1)) begin
         symbol = neg_ff ? jsu_pkg::SYM_NEG : jsu_pkg::SYM_POS;
      end else begin
         symbol = jsu_pkg::SYM_ZERO;
      end
   end

endmodule

// ===== rtl/jsu_ctrl.sv =====
// Sequencer for load, iteration and result strobe.
module jsu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  jsu_pkg::status_type status,
   output jsu_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);

   jsu_pkg::state_type state_ff, state_in;
   logic               valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jsu_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      cmd      = '0;
      busy     = 1'b0;
      case (state_ff)
         jsu_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = jsu_pkg::ST_RUN;
            end
         end
         jsu_pkg::ST_RUN: begin
            busy = 1'b1;
            if (status.a_zero) begin
               valid_in = 1'b1;
               state_in = jsu_pkg::ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = jsu_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = valid_ff;

endmodule

// ===== rtl/jacobi_symbol_u64_core.sv =====
// Top level of the 64-bit Jacobi symbol core.
// The rsp_valid strobe is registered once the loop sees the a operand reach zero.
// One reduction step per cycle: a halving, or a subtract-and-swap with halving.
// Throughput: one transaction at a time; busy is high while the loop runs.
// Reset (synchronous, active high) returns the sequencer to idle, no strobe.
// The result shows for one cycle; the receiver cannot stall it.
module jacobi_symbol_u64_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [jsu_pkg::WORD_W-1:0]       req_a_value,
   input  logic [jsu_pkg::WORD_W-1:0]       req_n_modulus,
   output logic                             rsp_valid,
   output logic signed [jsu_pkg::SYM_W-1:0] rsp_symbol
);

   jsu_pkg::cmd_type    cmd;
   jsu_pkg::status_type status;

   jsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   jsu_datapath u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .a_value   (req_a_value),
      .n_modulus (req_n_modulus),
      .status    (status),
      .symbol    (rsp_symbol)
   );

endmodule

// ===== rtl/jsu_checker.sv =====
// Port-level checks for the Jacobi symbol core.
module jsu_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic signed [jsu_pkg::SYM_W-1:0] rsp_symbol
);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_symbol_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_symbol != 2'sb10))
      else $error("illegal symbol code");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("transaction ended without result");

endmodule

bind jacobi_symbol_u64_core jsu_checker u_jsu_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_symbol (rsp_symbol)
);
